FILE: rtl/utf8_stream_decode_validate_defines.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODE_VALIDATE_DEFINES_SVH
`define UTF8_STREAM_DECODE_VALIDATE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define U8SDV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another on the same edge.
`define U8SDV_ASSERT_IMPL(lbl, cond, cons, msg) \
  `U8SDV_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

FILE: rtl/u8sdv_pkg.sv
// Package: constants, result type and length check for the UTF-8 decoder.
`timescale 1ns / 1ps
package u8sdv_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned RemW    = 2;
  localparam int unsigned LenW    = 3;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 3;

  // Lead-byte class boundaries
  localparam logic [ByteW-1:0] LeadAsciiMax = 8'h80;
  localparam logic [ByteW-1:0] LeadContMax  = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Max     = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Max     = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Max     = 8'hF8;

  // Shortest-form limits
  localparam logic [CpW-1:0] Limit1B = 21'h00080;
  localparam logic [CpW-1:0] Limit2B = 21'h00800;
  localparam logic [CpW-1:0] Limit3B = 21'h10000;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  localparam logic [1:0] ContTag = 2'b10;

  typedef struct packed {
    logic           string_ok;
    logic           string_end;
    logic           error;
    logic           char_valid;
    logic [CpW-1:0] code_point;
  } result_t;

  // True when the value uses exactly the number of bytes its size demands.
  function automatic logic length_ok(input logic [CpW-1:0] v, input logic [LenW-1:0] len);
    logic ok;
    if (v < Limit1B) begin
      ok = (len == Len1);
    end else if (v < Limit2B) begin
      ok = (len == Len2);
    end else if (v < Limit3B) begin
      ok = (len == Len3);
    end else begin
      ok = (len == Len4);
    end
    return ok;
  endfunction

endpackage

FILE: rtl/utf8_stream_decode_validate.sv
// UTF-8 byte stream decoder and validator, top level.
//
// Usage: bytes of a string enter on the s_axis channel, one beat per byte,
// with s_axis_tlast_i high on the last byte of the string. Each byte that
// completes a character, reveals a malformed sequence or ends the string
// gives one beat on m_axis; other bytes give none. m_axis_tlast_o marks the
// beat of the string's last byte, and m_axis_tuser_o[2] then says whether
// the whole string was well formed. After an error the rest of the string
// is dropped silently until its last byte.
// Each result beat is registered in the output stage before it leaves.
// Throughput: one byte per cycle while s_axis_tready_o is high; the decode state
// is one register stage updated by a single pass of logic per byte.
// Reset clears the decode state and empties the output stage.
// The result register is backed by a one-beat skid buffer, so a byte is
// still taken while one result waits; once both hold a beat and the
// receiver stalls, s_axis_tready_o drops until the output moves again.
`timescale 1ns / 1ps
module utf8_stream_decode_validate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [u8sdv_pkg::ByteW-1:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic                          s_axis_tlast_i,   // end_of_string
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [u8sdv_pkg::OutDataW-1:0] m_axis_tdata_o,  // [20:0] code_point, [23:21] zero
  output logic [u8sdv_pkg::OutUserW-1:0] m_axis_tuser_o,  // [0] char_valid, [1] error,
                                                           // [2] string_ok
  output logic                          m_axis_tlast_o    // string_end
);
  import u8sdv_pkg::*;

  `include "utf8_stream_decode_validate_defines.svh"

  logic [RemW-1:0] rem_q, rem_d;
  logic [LenW-1:0] len_q, len_d;
  logic [CpW-1:0]  acc_q, acc_d;
  logic            err_seen_q, err_seen_d;

  logic            out_valid_q, skid_valid_q;
  result_t         out_q, skid_q;

  logic            accept, pop, has_result;
  logic            err, done, eos;
  logic [CpW-1:0]  shifted;
  logic [ByteW-1:0] b;
  result_t         res;

  assign b   = s_axis_tdata_i;
  assign eos = s_axis_tlast_i;
  assign shifted = {acc_q[CpW-7:0], b[5:0]};

  always_comb begin
    rem_d      = rem_q;
    len_d      = len_q;
    acc_d      = acc_q;
    err_seen_d = err_seen_q;
    err        = 1'b0;
    done       = 1'b0;
    res        = '0;
    if (!err_seen_q) begin
      if (rem_q == '0) begin
        priority if (b < LeadAsciiMax) begin
          res.code_point = {{(CpW-ByteW){1'b0}}, b};
          done = 1'b1;
        end else if (b < LeadContMax) begin
          err = 1'b1;
        end else if (b < Lead2Max) begin
          len_d = Len2;
          rem_d = 2'd1;
          acc_d = {{(CpW-5){1'b0}}, b[4:0]};
        end else if (b < Lead3Max) begin
          len_d = Len3;
          rem_d = 2'd2;
          acc_d = {{(CpW-4){1'b0}}, b[3:0]};
        end else if (b < Lead4Max) begin
          len_d = Len4;
          rem_d = 2'd3;
          acc_d = {{(CpW-3){1'b0}}, b[2:0]};
        end else begin
          err = 1'b1;
        end
      end else if (b[7:6] != ContTag) begin
        err = 1'b1;
      end else begin
        acc_d = shifted;
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          if (length_ok(shifted, len_q)) begin
            res.code_point = shifted;
            done = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      end
      // cut off by the end of the string
      if (!err && eos && rem_d != '0) begin
        err = 1'b1;
      end
    end
    if (err) begin
      err_seen_d = 1'b1;
      rem_d      = '0;
      len_d      = '0;
      acc_d      = '0;
    end
    if (done) begin
      len_d = '0;
      acc_d = '0;
    end
    if (eos) begin
      err_seen_d = 1'b0;
      rem_d      = '0;
      len_d      = '0;
      acc_d      = '0;
    end
    res.char_valid = done;
    res.error      = err;
    res.string_end = eos;
    res.string_ok  = eos & ~err_seen_q & ~err;
  end

  assign has_result = done | err | eos;
  assign accept     = s_axis_tvalid_i & s_axis_tready_o;
  assign pop        = out_valid_q & m_axis_tready_i;
  assign s_axis_tready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      len_q      <= '0;
      acc_q      <= '0;
      err_seen_q <= 1'b0;
    end else if (accept) begin
      rem_q      <= rem_d;
      len_q      <= len_d;
      acc_q      <= acc_d;
      err_seen_q <= err_seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept && has_result) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: refill the result register from the skid, else take the new beat
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept && has_result) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-CpW){1'b0}}, out_q.code_point};
  assign m_axis_tuser_o  = {out_q.string_ok, out_q.error, out_q.char_valid};
  assign m_axis_tlast_o  = out_q.string_end;

  `U8SDV_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q,
                     "skid buffer full while result register empty")
  `U8SDV_ASSERT_IMPL(a_len_tracks_rem, rem_q != '0, len_q > {1'b0, rem_q},
                     "sequence length not above bytes still expected")
  `U8SDV_ASSERT_IMPL(a_drop_no_pending, err_seen_q, rem_q == '0 && acc_q == '0,
                     "sequence still pending while dropping after an error")
  `U8SDV_ASSERT(a_eos_clears, accept && eos |=> (rem_q == '0 && !err_seen_q),
                "decode state not cleared after end of string")

endmodule
